FILE: hw/rtl/bst_pkg.sv
package bst_pkg;

    localparam logic [4:0] KIND_INT  = 5'd0;
    localparam logic [4:0] KIND_ID   = 5'd1;
    localparam logic [4:0] KIND_STR  = 5'd2;
    localparam logic [4:0] KIND_LPAR = 5'd3;
    localparam logic [4:0] KIND_RPAR = 5'd4;
    localparam logic [4:0] KIND_LT   = 5'd5;
    localparam logic [4:0] KIND_GT   = 5'd6;
    localparam logic [4:0] KIND_LBRC = 5'd7;
    localparam logic [4:0] KIND_RBRC = 5'd8;
    localparam logic [4:0] KIND_COMA = 5'd9;
    localparam logic [4:0] KIND_DOT  = 5'd10;
    localparam logic [4:0] KIND_SEMI = 5'd11;
    localparam logic [4:0] KIND_EQ   = 5'd12;
    localparam logic [4:0] KIND_EQEQ = 5'd13;
    localparam logic [4:0] KIND_EQGT = 5'd14;
    localparam logic [4:0] KIND_EQLT = 5'd15;
    localparam logic [4:0] KIND_EOF  = 5'd16;
    localparam logic [4:0] KIND_ERR  = 5'd17;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] text;
        logic       has;
        logic       first;
        logic       last;
    } t_result;

    // one queue entry: all results caused by one input byte
    typedef struct packed {
        t_result [1:0] res;
        logic          two;
        logic [15:0]   line;
    } t_entry;

endpackage

FILE: hw/rtl/bst_front.sv
module bst_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char_byte,
    input  logic              i_full,
    output logic              o_push,
    output bst_pkg::t_entry   o_entry
);

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_INT  = 3'd1;
    localparam logic [2:0] MODE_ID   = 3'd2;
    localparam logic [2:0] MODE_STR  = 3'd3;
    localparam logic [2:0] MODE_EQ   = 3'd4;
    localparam logic [2:0] MODE_ERR  = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    function automatic bst_pkg::t_result mk(input logic [4:0] kind, input logic [7:0] b,
                                            input logic has, input logic first,
                                            input logic last);
        bst_pkg::t_result r;
        r.kind  = kind;
        r.text  = has ? b : 8'd0;
        r.has   = has;
        r.first = first;
        r.last  = last;
        return r;
    endfunction

    logic [2:0]  r_mode, n_mode;
    logic [7:0]  r_held, n_held;
    logic        r_held_v, n_held_v;
    logic        r_held_f, n_held_f;
    logic [15:0] r_line, n_line;

    logic             accept;
    logic [7:0]       c;
    logic             is_dig, is_alp, is_spc;
    logic             pk_ok;
    logic [4:0]       pk;
    logic [2:0]       st_mode;
    logic             st_hold, st_emit, st_eof;
    bst_pkg::t_result st_res;
    logic             use_start, goes_on, a_v, b_v;
    bst_pkg::t_result res_a, res_b;

    assign accept = i_valid && !i_full;
    assign c      = i_char_byte;
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);
    assign is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_spc = (c == CH_CR) || (c == CH_LF) || (c == CH_SPACE) || (c == CH_TAB);

    always_comb begin
        pk_ok = 1'b1;
        unique case (c)
            8'h28:   pk = bst_pkg::KIND_LPAR;
            8'h29:   pk = bst_pkg::KIND_RPAR;
            CH_LT:   pk = bst_pkg::KIND_LT;
            CH_GT:   pk = bst_pkg::KIND_GT;
            8'h7B:   pk = bst_pkg::KIND_LBRC;
            8'h7D:   pk = bst_pkg::KIND_RBRC;
            8'h2C:   pk = bst_pkg::KIND_COMA;
            8'h2E:   pk = bst_pkg::KIND_DOT;
            8'h3B:   pk = bst_pkg::KIND_SEMI;
            default: begin
                pk    = bst_pkg::KIND_ERR;
                pk_ok = 1'b0;
            end
        endcase
    end

    // what the byte does when it arrives between tokens
    always_comb begin
        st_mode = MODE_IDLE;
        st_hold = 1'b0;
        st_emit = 1'b0;
        st_eof  = 1'b0;
        st_res  = '0;
        priority if (c == CH_NUL) begin
            st_emit = 1'b1;
            st_eof  = 1'b1;
            st_res  = mk(bst_pkg::KIND_EOF, CH_NUL, 1'b0, 1'b1, 1'b1);
        end else if (is_spc) begin
            st_mode = MODE_IDLE;
        end else if (is_dig) begin
            st_mode = MODE_INT;
            st_hold = 1'b1;
        end else if (is_alp) begin
            st_mode = MODE_ID;
            st_hold = 1'b1;
        end else if (c == CH_QUOTE) begin
            st_mode = MODE_STR;
        end else if (c == CH_EQ) begin
            st_mode = MODE_EQ;
            st_hold = 1'b1;
        end else if (pk_ok) begin
            st_emit = 1'b1;
            st_res  = mk(pk, c, 1'b1, 1'b1, 1'b1);
        end else begin
            st_emit = 1'b1;
            st_mode = MODE_ERR;
            st_res  = mk(bst_pkg::KIND_ERR, c, 1'b1, 1'b1, 1'b1);
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_held_f  = r_held_f;
        use_start = 1'b0;
        goes_on   = 1'b0;
        a_v       = 1'b0;
        b_v       = 1'b0;
        res_a     = '0;
        res_b     = '0;
        unique case (r_mode)
            MODE_INT, MODE_ID: begin
                goes_on = (r_mode == MODE_INT) ? is_dig : (is_dig || is_alp);
                a_v     = 1'b1;
                res_a   = mk((r_mode == MODE_INT) ? bst_pkg::KIND_INT : bst_pkg::KIND_ID,
                             r_held, 1'b1, r_held_f, !goes_on);
                if (goes_on) begin
                    n_held   = c;
                    n_held_v = 1'b1;
                    n_held_f = 1'b0;
                end else begin
                    use_start = 1'b1;
                end
            end
            MODE_STR: begin
                priority if (c == CH_QUOTE) begin
                    a_v      = 1'b1;
                    res_a    = r_held_v ? mk(bst_pkg::KIND_STR, r_held, 1'b1, r_held_f, 1'b1)
                                        : mk(bst_pkg::KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b1);
                    n_mode   = MODE_IDLE;
                    n_held_v = 1'b0;
                    n_held_f = 1'b0;
                end else if (c == CH_NUL) begin
                    // unterminated string
                    a_v      = 1'b1;
                    res_a    = mk(bst_pkg::KIND_ERR, CH_NUL, 1'b0, 1'b1, 1'b1);
                    n_mode   = MODE_ERR;
                    n_held_v = 1'b0;
                    n_held_f = 1'b0;
                end else if (r_held_v) begin
                    a_v      = 1'b1;
                    res_a    = mk(bst_pkg::KIND_STR, r_held, 1'b1, r_held_f, 1'b0);
                    n_held   = c;
                    n_held_f = 1'b0;
                end else begin
                    n_held   = c;
                    n_held_v = 1'b1;
                    n_held_f = 1'b1;
                end
            end
            MODE_EQ: begin
                a_v = 1'b1;
                if ((c == CH_EQ) || (c == CH_GT) || (c == CH_LT)) begin
                    b_v      = 1'b1;
                    res_a    = mk((c == CH_EQ) ? bst_pkg::KIND_EQEQ :
                                  (c == CH_GT) ? bst_pkg::KIND_EQGT : bst_pkg::KIND_EQLT,
                                  CH_EQ, 1'b1, 1'b1, 1'b0);
                    res_b    = mk(res_a.kind, c, 1'b1, 1'b0, 1'b1);
                    n_mode   = MODE_IDLE;
                    n_held_v = 1'b0;
                    n_held_f = 1'b0;
                end else begin
                    res_a     = mk(bst_pkg::KIND_EQ, CH_EQ, 1'b1, 1'b1, 1'b1);
                    use_start = 1'b1;
                end
            end
            MODE_ERR: begin
                n_mode = MODE_ERR;
            end
            default: begin
                use_start = 1'b1;
            end
        endcase
        if (use_start) begin
            n_mode   = st_mode;
            n_held   = c;
            n_held_v = st_hold;
            n_held_f = st_hold;
            b_v      = st_emit;
            res_b    = st_res;
        end
    end

    always_comb begin
        n_line = r_line;
        if (use_start && st_eof) begin
            n_line = 16'd1;
        end else if ((c == CH_LF) && (r_mode != MODE_ERR) && (r_line != bst_pkg::LINE_MAX)) begin
            n_line = r_line + 16'd1;
        end
    end

    always_comb begin
        o_entry.line = r_line;
        if (a_v) begin
            o_entry.res[0] = res_a;
            o_entry.res[1] = res_b;
            o_entry.two    = b_v;
        end else begin
            o_entry.res[0] = res_b;
            o_entry.res[1] = res_b;
            o_entry.two    = 1'b0;
        end
    end

    assign o_push = accept && (a_v || b_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_held   <= 8'd0;
            r_held_v <= 1'b0;
            r_held_f <= 1'b0;
            r_line   <= 16'd1;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_held_f <= n_held_f;
            r_line   <= n_line;
        end
    end

endmodule

FILE: hw/rtl/bst_queue.sv
module bst_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bst_pkg::t_entry i_entry,
    input  logic            i_pop,
    output bst_pkg::t_entry o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bst_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/bst_back.sv
module bst_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bst_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [4:0]      o_token_kind,
    output logic [7:0]      o_text_byte,
    output logic            o_has_text,
    output logic            o_token_first,
    output logic            o_token_last,
    output logic [15:0]     o_line_number,
    output logic            o_run_last
);

    logic             r_valid;
    logic             r_sub;
    bst_pkg::t_result r_res;
    logic [15:0]      r_line;
    logic             r_run_last;

    logic free, load, last_slot;

    assign free      = !r_valid || !i_stall;
    assign load      = free && !i_empty;
    // second slot, or the only one
    assign last_slot = r_sub || !i_head.two;
    assign o_pop     = load && last_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (free) begin
            r_valid <= load;
            if (load) begin
                r_sub <= !last_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res      <= i_head.res[r_sub];
            r_line     <= i_head.line;
            r_run_last <= last_slot;
        end
    end

    assign o_valid       = r_valid;
    assign o_token_kind  = r_res.kind;
    assign o_text_byte   = r_res.text;
    assign o_has_text    = r_res.has;
    assign o_token_first = r_res.first;
    assign o_token_last  = r_res.last;
    assign o_line_number = r_line;
    assign o_run_last    = r_run_last;

endmodule

FILE: hw/rtl/byte_stream_tokenizer_core.sv
// Tokenizer for a byte stream, one source byte per request (byte 0 ends the input).
// The front end classifies a byte in the cycle it is taken and files every result that
// byte causes as one entry of a QUEUE_DEPTH-entry queue; the back end sends those results
// one per cycle from an output register while i_stall is low. A byte is taken every cycle
// while the queue has room; its results pass through the queue, then the output register.
// A byte causes no result for whitespace between tokens and two for "==", "=>", "=<" and
// for a byte that both closes and opens a token, so the sustained rate is one byte per
// cycle while i_stall is low, the output side being the limit when dense in such pairs.
module byte_stream_tokenizer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_token_kind,
    output logic [7:0]  o_text_byte,
    output logic        o_has_text,
    output logic        o_token_first,
    output logic        o_token_last,
    output logic [15:0] o_line_number,
    output logic        o_run_last
);

    logic            push, pop, empty, full;
    bst_pkg::t_entry entry, head;

    bst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_byte (i_char_byte),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (entry)
    );

    bst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    bst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_token_kind  (o_token_kind),
        .o_text_byte   (o_text_byte),
        .o_has_text    (o_has_text),
        .o_token_first (o_token_first),
        .o_token_last  (o_token_last),
        .o_line_number (o_line_number),
        .o_run_last    (o_run_last)
    );

    assign o_stall = full;

endmodule

FILE: hw/rtl/bst_checker.sv
module bst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [4:0]  o_token_kind,
    input logic [7:0]  o_text_byte,
    input logic        o_has_text,
    input logic        o_token_first,
    input logic        o_token_last,
    input logic        o_run_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) && $stable(o_text_byte))
        else $error("result changed while stalled");

    a_no_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_text |-> o_text_byte == 8'd0)
        else $error("text byte set without text");

    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == bst_pkg::KIND_EOF |->
            o_token_first && o_token_last && !o_has_text && o_run_last)
        else $error("malformed eof result");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_kind <= bst_pkg::KIND_ERR)
        else $error("token kind out of range");

    // an error is sticky, nothing follows it
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_token_kind == bst_pkg::KIND_ERR |=> !o_valid)
        else $error("result after error");

endmodule

bind byte_stream_tokenizer_core bst_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_token_kind  (o_token_kind),
    .o_text_byte   (o_text_byte),
    .o_has_text    (o_has_text),
    .o_token_first (o_token_first),
    .o_token_last  (o_token_last),
    .o_run_last    (o_run_last)
);
